/* hw/rtl/kst_pkg.sv */
`timescale 1ns / 1ps
package kst_pkg;
   localparam int Entries = 64;
   localparam int KeyBytes = 32;
   localparam int SlotW = $clog2(Entries);
   localparam int CntW = $clog2(Entries + 1);

   localparam logic [1:0] FUNC_BUMP  = 2'd0;
   localparam logic [1:0] FUNC_FIND  = 2'd1;
   localparam logic [1:0] FUNC_GET   = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key_word_0;
      logic [63:0] key_word_1;
      logic [63:0] key_word_2;
      logic [63:0] key_word_3;
      logic [63:0] now;
      logic [5:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [5:0]  slot;
      logic [31:0] record_count;
      logic [63:0] first_stamp;
      logic [63:0] last_stamp;
      logic [63:0] out_key_0;
      logic [63:0] out_key_1;
      logic [63:0] out_key_2;
      logic [63:0] out_key_3;
      logic [6:0]  entries_used;
      logic [31:0] total_sightings;
   } rsp_type;

   // Clear bytes after the first zero byte and at or beyond KeyBytes-1.
   function automatic logic [255:0] normalize_key(input logic [255:0] raw);
      logic [255:0] k;
      logic         ended;
      k = '0;
      ended = 1'b0;
      for (int b = 0; b < 32; b++) begin
         if (raw[b*8 +: 8] == 8'd0) ended = 1'b1;
         if (!ended && b < KeyBytes - 1) k[b*8 +: 8] = raw[b*8 +: 8];
      end
      return k;
   endfunction
endpackage

/* hw/rtl/keyed_sighting_counter_table_top.sv */
`timescale 1ns / 1ps
// Associative counting table of Entries records held in one synchronous memory
// (key, count, first, last in one row). Bump and find scan the used rows one per
// cycle with a registered read, a bump writing its row back once the scan ends.
// Get reads the addressed row directly; clear goes straight to the response.
// One transaction is worked at a time; the result sits in an output register,
// and the next request is taken once it has been delivered.
module keyed_sighting_counter_table_top
   import kst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   typedef struct packed {
      logic [255:0] key;
      logic [31:0]  cnt;
      logic [63:0]  first;
      logic [63:0]  last;
   } row_type;

   row_type mem [Entries];
   row_type rd_ff;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       func_ff;
   logic [255:0]     key_ff;
   logic [63:0]      now_ff;
   logic [SlotW-1:0] addr_ff, addr_in;     // address being read
   logic [SlotW-1:0] cmp_ff;               // address of rd_ff
   logic             cmpv_ff, cmpv_in;
   logic [CntW-1:0]  used_ff, used_in;
   logic [31:0]      total_ff, total_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rd_en, wr_en;
   row_type          wr_row;
   logic [SlotW-1:0] wr_addr;
   logic [CntW-1:0]  addr_ext;
   logic             hit;
   logic             last_rd;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign addr_ext  = CntW'(addr_ff);
   assign hit = cmpv_ff && (rd_ff.key == key_ff);
   assign last_rd = (addr_ext + 1'b1) >= used_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= mem[addr_ff];
      if (wr_en) mem[wr_addr] <= wr_row;
   end

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      cmpv_in  = 1'b0;
      used_in  = used_ff;
      total_in = total_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cmp_ff;
      wr_row   = rd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (req_valid && req_ready) begin
               unique case (req_data.func)
                  FUNC_CLEAR: state_in = ST_RESP;
                  FUNC_GET: begin
                     addr_in  = req_data.slot_index[SlotW-1:0];
                     state_in = ST_SCAN;
                  end
                  default: state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (func_ff == FUNC_GET) begin
               rd_en = 1'b1;
               state_in = ST_WAIT;
            end else if (hit) begin
               cmpv_in = 1'b1;
               state_in = ST_DONE;
            end else if (addr_ext < used_ff) begin
               rd_en = 1'b1;
               cmpv_in = 1'b1;
               addr_in = addr_ff + 1'b1;
               if (last_rd) state_in = ST_WAIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WAIT: state_in = ST_DONE;
         ST_DONE: begin
            state_in = ST_RESP;
            if (func_ff == FUNC_BUMP) begin
               if (hit) begin
                  wr_en = 1'b1;
                  wr_row.cnt  = rd_ff.cnt + 32'd1;
                  wr_row.last = now_ff;
                  total_in = total_ff + 32'd1;
               end else if (used_ff < CntW'(Entries)) begin
                  wr_en = 1'b1;
                  wr_addr = used_ff[SlotW-1:0];
                  wr_row.key = key_ff;
                  wr_row.cnt = 32'd1;
                  wr_row.first = now_ff;
                  wr_row.last = now_ff;
                  used_in = used_ff + 1'b1;
                  total_in = total_ff + 32'd1;
               end
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
            if (func_ff == FUNC_CLEAR) begin
               used_in = '0;
               total_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (state_ff == ST_DONE) begin
         rsp_in = '0;
         if ((func_ff == FUNC_GET && CntW'(cmp_ff) < used_ff) || hit ||
             (func_ff == FUNC_BUMP && used_ff < CntW'(Entries))) begin
            rsp_in.ok           = 1'b1;
            rsp_in.slot         = hit || func_ff == FUNC_GET ?
                                  6'(cmp_ff) : 6'(used_ff);
            rsp_in.record_count = wr_row.cnt;
            rsp_in.first_stamp  = wr_row.first;
            rsp_in.last_stamp   = wr_row.last;
            rsp_in.out_key_0    = wr_row.key[63:0];
            rsp_in.out_key_1    = wr_row.key[127:64];
            rsp_in.out_key_2    = wr_row.key[191:128];
            rsp_in.out_key_3    = wr_row.key[255:192];
         end
      end
      if (state_ff == ST_RESP) begin
         if (func_ff == FUNC_CLEAR) begin
            rsp_in = '0;
            rsp_in.ok = 1'b1;
         end
         rsp_in.entries_used    = 7'(used_in);
         rsp_in.total_sightings = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         cmpv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         total_ff <= total_in;
         // hold the compare flag through the wait so a hit on the final row is seen
         if (state_ff == ST_SCAN || state_ff == ST_IDLE) cmpv_ff <= cmpv_in;
         if (state_ff == ST_RESP) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
      if (rd_en) cmp_ff <= addr_ff;
      if (req_valid && req_ready) begin
         func_ff <= req_data.func;
         now_ff  <= req_data.now;
         key_ff  <= normalize_key({req_data.key_word_3, req_data.key_word_2,
                                   req_data.key_word_1, req_data.key_word_0});
      end
   end

`ifndef SYNTH
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntW'(Entries)) else $error("used count beyond table");
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_ff != $past(used_ff)) && !$past(reset) |->
      (used_ff == '0 || used_ff == $past(used_ff) + 1'b1))
      else $error("used count jumped");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("busy while result pending");
`endif
endmodule
